// ===== rtl/core/natpt_pkg.sv =====
package natpt_pkg;

   localparam int unsigned TABLE_ENTRIES_DEFAULT = 256;
   localparam logic [15:0] PORT_BASE_RESET       = 16'd8000;
   localparam int unsigned PORT_SPACE            = 65536;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_LOOKUP  = 2'd1;
   localparam logic [1:0] OP_REVERSE = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;

   localparam logic REG_PORT_BASE = 1'b0;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] src_addr;
      logic [15:0] orig_port;
      logic [15:0] mapped_port;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_addr;
      logic [15:0] found_port;
      logic [15:0] assigned_port;
      logic [8:0]  count_now;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] port;
   } entry_type;

endpackage

// ===== rtl/core/natpt_mem.sv =====
module natpt_mem #(
   parameter int unsigned DEPTH = natpt_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IW-1:0]        wr_addr,
   input  natpt_pkg::entry_type wr_data,
   input  logic                 rd_en,
   input  logic [IW-1:0]        rd_addr,
   output natpt_pkg::entry_type rd_data_ff
);

   natpt_pkg::entry_type mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/core/natpt_ctrl.sv =====
module natpt_ctrl #(
   parameter int unsigned TABLE_ENTRIES = natpt_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   parameter int unsigned CW = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  natpt_pkg::req_type   req_data,
   input  logic [15:0]          port_base,
   output logic                 rsp_valid,
   output natpt_pkg::rsp_type   rsp_data,
   output logic                 wr_en,
   output logic [IW-1:0]        wr_addr,
   output natpt_pkg::entry_type wr_data,
   output logic                 rd_en,
   output logic [IW-1:0]        rd_addr,
   input  natpt_pkg::entry_type rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REV
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      chk_ff, chk_in;
   natpt_pkg::req_type req_ff, req_in;
   natpt_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [16:0] port_end;
   logic        full;
   logic [15:0] rev_idx;
   logic        rev_hit;
   logic        scan_hit;
   logic        scan_last;

   always_comb begin
      port_end  = {1'b0, port_base} + 17'(count_ff);
      full      = (count_ff == CW'(TABLE_ENTRIES)) || port_end[16];
      rev_idx   = req_data.mapped_port - port_base;
      rev_hit   = 17'(rev_idx) < 17'(count_ff);
      scan_hit  = (rd_data.addr == req_ff.src_addr) && (rd_data.port == req_ff.orig_port);
      scan_last = (CW'(chk_ff) + CW'(1)) == count_ff;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      chk_in       = chk_ff;
      req_in       = req_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IW-1:0];
      wr_data      = {req_data.src_addr, req_data.orig_port};
      rd_en        = 1'b0;
      rd_addr      = chk_ff + IW'(1);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.operation)
                  natpt_pkg::OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in.status = natpt_pkg::STAT_FULL;
                     end else begin
                        wr_en                = 1'b1;
                        count_in             = count_ff + CW'(1);
                        rsp_in.status        = natpt_pkg::STAT_OK;
                        rsp_in.assigned_port = port_base + 16'(count_ff);
                     end
                  end
                  natpt_pkg::OP_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = natpt_pkg::STAT_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        chk_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  natpt_pkg::OP_REVERSE: begin
                     if (rev_hit) begin
                        rd_en    = 1'b1;
                        rd_addr  = rev_idx[IW-1:0];
                        state_in = S_REV;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = natpt_pkg::STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = natpt_pkg::STAT_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // rd_data holds entry chk_ff; the next entry is fetched meanwhile unless the scan ends
            if (scan_hit) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = natpt_pkg::STAT_OK;
               rsp_in.assigned_port = port_base + 16'(chk_ff);
               state_in             = S_IDLE;
            end else if (scan_last) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = natpt_pkg::STAT_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               rd_en  = 1'b1;
               chk_in = chk_ff + IW'(1);
            end
         end
         S_REV: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = natpt_pkg::STAT_OK;
            rsp_in.found_addr    = rd_data.addr;
            rsp_in.found_port    = rd_data.port;
            rsp_in.assigned_port = req_ff.mapped_port;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_in.count_now = 9'(count_in);
   end

   always_ff @(posedge clock) begin
      chk_ff <= chk_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/nat_port_mapping_table_core.sv =====
// NAT port translation table.
// Items enter on req_data when start is high and busy is low. Each item gives
// exactly one result on rsp_data, shown for one cycle with rsp_valid high;
// the receiver has no way to stall it, so it must take every result.
// Operations: insert (append pair, outside port = base + index), forward
// lookup (oldest matching pair), reverse lookup (outside port back to pair),
// clear (empty the table).
// Path from accept to result:
//   insert, clear, misses decided at once: result registered, busy never rises.
//   reverse lookup hit: one table read, then the result.
//   forward lookup: scans entries from index 0 up to the first match or,
//   on a miss, the last entry; the table has one read port and the scan
//   checks one entry per cycle, reading the next entry meanwhile.
// port_base is written via APB where paddr[2] is low; the user must write it
// only while idle, the block does not enforce it. Reset empties the table at
// once (no clearing pass: only entries below the count are ever read) and sets port_base to 8000.
module nat_port_mapping_table_core #(
   parameter int unsigned TABLE_ENTRIES = natpt_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  natpt_pkg::req_type req_data,
   output logic               rsp_valid,
   output natpt_pkg::rsp_type rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

   logic [15:0]          port_base_ff;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   natpt_pkg::entry_type wr_data;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   natpt_pkg::entry_type rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_base_ff <= natpt_pkg::PORT_BASE_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == natpt_pkg::REG_PORT_BASE)) begin
         port_base_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr[2] == natpt_pkg::REG_PORT_BASE) ? {16'd0, port_base_ff} : '0;
   assign pready = 1'b1;

   natpt_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IW(IW),
      .CW(CW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .port_base(port_base_ff),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   natpt_mem #(
      .DEPTH(TABLE_ENTRIES),
      .IW(IW)
   ) u_mem (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data_ff(rd_data)
   );

   // every accepted item either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted item neither answered nor in progress");

   a_insert_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == natpt_pkg::OP_INSERT)) |=> rsp_valid)
      else $error("insert result missing");

   // the end of a scan or a table read always delivers its result
   a_busy_end_result: assert property (@(posedge clock) disable iff (reset || $past(reset))
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr_en)
      else $error("table written during a multi-cycle operation");

endmodule
